FILE: sv/integral_symmetry_unfolder_assert.svh
// Assertion macros used by the checker file of the integral symmetry unfolder.
`ifndef INTEGRAL_SYMMETRY_UNFOLDER_ASSERT_SVH
`define INTEGRAL_SYMMETRY_UNFOLDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ISU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ISU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/isu_pkg.sv
// Types, constants and copy tables of the integral symmetry unfolder.
package isu_pkg;

    localparam int VAL_W = 48;
    localparam int THR_W = 47;
    localparam int CNT_W = 32;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(4295);

    // index coincidence class, first match wins
    typedef enum logic [2:0] {
        CASE_ALL     = 3'd0,
        CASE_AB_CD   = 3'd1,
        CASE_AB      = 3'd2,
        CASE_CD      = 3'd3,
        CASE_AC_BD   = 3'd4,
        CASE_AD_BC   = 3'd5,
        CASE_DISTINCT = 3'd6
    } copy_case_t;

    // four 2-bit source positions (0=a .. 3=d), first position in the lowest bits
    typedef logic [7:0] perm_t;

    localparam perm_t P_ABCD = {2'd3, 2'd2, 2'd1, 2'd0};
    localparam perm_t P_CDAB = {2'd1, 2'd0, 2'd3, 2'd2};
    localparam perm_t P_ABDC = {2'd2, 2'd3, 2'd1, 2'd0};
    localparam perm_t P_DCAB = {2'd1, 2'd0, 2'd2, 2'd3};
    localparam perm_t P_BACD = {2'd3, 2'd2, 2'd0, 2'd1};
    localparam perm_t P_CDBA = {2'd0, 2'd1, 2'd3, 2'd2};
    localparam perm_t P_BADC = {2'd2, 2'd3, 2'd0, 2'd1};
    localparam perm_t P_DCBA = {2'd0, 2'd1, 2'd2, 2'd3};

    function automatic perm_t copy_perm(input copy_case_t cs, input logic [2:0] k);
        perm_t p;
        p = P_ABCD;
        unique case (cs)
            CASE_ALL: p = P_ABCD;
            CASE_AB_CD: p = (k[0]) ? P_CDAB : P_ABCD;
            CASE_AB: begin
                unique case (k[1:0])
                    2'd0: p = P_ABCD;
                    2'd1: p = P_CDAB;
                    2'd2: p = P_ABDC;
                    default: p = P_DCAB;
                endcase
            end
            CASE_CD: begin
                unique case (k[1:0])
                    2'd0: p = P_ABCD;
                    2'd1: p = P_CDAB;
                    2'd2: p = P_BACD;
                    default: p = P_CDBA;
                endcase
            end
            CASE_AC_BD: begin
                unique case (k[1:0])
                    2'd0: p = P_ABCD;
                    2'd1: p = P_BACD;
                    2'd2: p = P_CDBA;
                    default: p = P_BADC;
                endcase
            end
            CASE_AD_BC: begin
                unique case (k[1:0])
                    2'd0: p = P_ABCD;
                    2'd1: p = P_CDAB;
                    2'd2: p = P_BACD;
                    default: p = P_ABDC;
                endcase
            end
            default: begin
                unique case (k)
                    3'd0: p = P_ABCD;
                    3'd1: p = P_CDAB;
                    3'd2: p = P_BACD;
                    3'd3: p = P_CDBA;
                    3'd4: p = P_ABDC;
                    3'd5: p = P_DCAB;
                    3'd6: p = P_BADC;
                    default: p = P_DCBA;
                endcase
            end
        endcase
        return p;
    endfunction

    // index of the final copy of each class
    function automatic logic [2:0] copy_last(input copy_case_t cs);
        logic [2:0] n;
        n = 3'd0;
        unique case (cs)
            CASE_ALL: n = 3'd0;
            CASE_AB_CD: n = 3'd1;
            CASE_AB, CASE_CD, CASE_AC_BD, CASE_AD_BC: n = 3'd3;
            default: n = 3'd7;
        endcase
        return n;
    endfunction

endpackage

FILE: sv/integral_symmetry_unfolder.sv
// Integral symmetry unfolder: expands one two-electron integral into its symmetry copies.
//
//  channel   direction  handshake            payload
//  cfg       in         cfg_valid/cfg_ready  cfg_data: drop threshold (47 bits)
//  s_        in         s_tvalid/s_tready    s_tdata: orb_a..orb_d, integral_value
//  m_        out        m_tvalid/m_tready    m_tdata, m_tuser (dropped), m_tlast (last copy)
//
//  An accepted word is classified (magnitude compare, index coincidence) and held in an
//  item register; while m_tready does not stall, one copy per cycle is then moved into the output register.
//  An item yields 1, 2, 4 or 8 result words, one per copy; the next word is taken in the
//  cycle its predecessor's last copy leaves.
//  aresetn (synchronous) empties both registers, clears the drop count and reloads the
//  threshold with 4295. A stall on m_tready holds the output word and the item register.
module integral_symmetry_unfolder #(
    parameter int INDEX_BITS = 8,
    localparam int S_BITS    = 4 * INDEX_BITS + isu_pkg::VAL_W,
    localparam int S_TDATA_W = ((S_BITS + 7) / 8) * 8,
    localparam int M_BITS    = 4 * INDEX_BITS + isu_pkg::VAL_W + isu_pkg::CNT_W,
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [isu_pkg::THR_W-1:0]  cfg_data,
    // input words
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // low to high: orb_a, orb_b, orb_c, orb_d, integral_value, zero pad
    input  logic [S_TDATA_W-1:0]       s_tdata,
    // result words
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // low to high: phys_p, phys_q, phys_r, phys_s, out_value, dropped_total, zero pad
    output logic [M_TDATA_W-1:0]       m_tdata,
    // dropped
    output logic [0:0]                 m_tuser,
    output logic                       m_tlast
);
    import isu_pkg::*;

    localparam int IB = INDEX_BITS;

    // configuration and counter
    logic [THR_W-1:0] thr_reg;
    logic [CNT_W-1:0] drop_cnt_reg, drop_cnt_next;

    // item register
    logic             hold_valid_reg, hold_valid_next;
    logic [IB-1:0]    ia_reg, ib_reg, ic_reg, id_reg;
    logic [VAL_W-1:0] val_reg;
    logic             drop_reg;
    logic [CNT_W-1:0] total_reg;
    copy_case_t       case_reg;
    logic [2:0]       k_reg, last_k_reg;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [IB-1:0]    p_reg, q_reg, r_reg, s_reg;
    logic [VAL_W-1:0] oval_reg;
    logic [CNT_W-1:0] otot_reg;
    logic             odrop_reg, olast_reg;

    // input unpack and classification
    logic [IB-1:0]    in_a, in_b, in_c, in_d;
    logic [VAL_W-1:0] in_val, in_mag;
    logic             in_drop;
    copy_case_t       in_case;
    logic             accept, emit, hold_done, out_free;
    perm_t            perm;

    assign in_a   = s_tdata[0*IB +: IB];
    assign in_b   = s_tdata[1*IB +: IB];
    assign in_c   = s_tdata[2*IB +: IB];
    assign in_d   = s_tdata[3*IB +: IB];
    assign in_val = s_tdata[4*IB +: VAL_W];

    // two's complement magnitude; the most negative value gives 2^47, never below threshold
    assign in_mag  = in_val[VAL_W-1] ? (~in_val + VAL_W'(1)) : in_val;
    assign in_drop = in_mag < {1'b0, thr_reg};

    always_comb begin
        priority if (in_a == in_b && in_a == in_c && in_a == in_d) in_case = CASE_ALL;
        else if (in_a == in_b && in_c == in_d) in_case = CASE_AB_CD;
        else if (in_a == in_b) in_case = CASE_AB;
        else if (in_c == in_d) in_case = CASE_CD;
        else if (in_a == in_c && in_b == in_d) in_case = CASE_AC_BD;
        else if (in_a == in_d && in_b == in_c) in_case = CASE_AD_BC;
        else in_case = CASE_DISTINCT;
    end

    // handshake
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = hold_valid_reg && out_free;
    assign hold_done = emit && (k_reg == last_k_reg);
    assign s_tready  = !hold_valid_reg || hold_done;
    assign accept    = s_tvalid && s_tready;

    // saturating drop count, bumped as the word is taken
    always_comb begin
        drop_cnt_next = drop_cnt_reg;
        if (accept && in_drop && drop_cnt_reg != '1) begin
            drop_cnt_next = drop_cnt_reg + CNT_W'(1);
        end
    end

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
        end else if (hold_done) begin
            hold_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    function automatic logic [IB-1:0] pick_idx(input logic [1:0] pos,
                                               input logic [IB-1:0] a, input logic [IB-1:0] b,
                                               input logic [IB-1:0] c, input logic [IB-1:0] d);
        logic [IB-1:0] v;
        v = a;
        unique case (pos)
            2'd0: v = a;
            2'd1: v = b;
            2'd2: v = c;
            default: v = d;
        endcase
        return v;
    endfunction

    assign perm = copy_perm(case_reg, k_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= THR_RESET;
            drop_cnt_reg   <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
            drop_cnt_reg   <= drop_cnt_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // item register payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            ia_reg     <= in_a;
            ib_reg     <= in_b;
            ic_reg     <= in_c;
            id_reg     <= in_d;
            val_reg    <= in_val;
            drop_reg   <= in_drop;
            total_reg  <= drop_cnt_next;
            case_reg   <= in_case;
            k_reg      <= 3'd0;
            last_k_reg <= in_drop ? 3'd0 : copy_last(in_case);
        end else if (emit) begin
            k_reg <= k_reg + 3'd1;
        end
    end

    // output register payload; physics order <p q | r s> = chemical (p r | q s)
    always_ff @(posedge aclk) begin
        if (emit) begin
            if (drop_reg) begin
                p_reg <= '0;
                q_reg <= '0;
                r_reg <= '0;
                s_reg <= '0;
            end else begin
                p_reg <= pick_idx(perm[1:0], ia_reg, ib_reg, ic_reg, id_reg);
                q_reg <= pick_idx(perm[5:4], ia_reg, ib_reg, ic_reg, id_reg);
                r_reg <= pick_idx(perm[3:2], ia_reg, ib_reg, ic_reg, id_reg);
                s_reg <= pick_idx(perm[7:6], ia_reg, ib_reg, ic_reg, id_reg);
            end
            oval_reg  <= val_reg;
            otot_reg  <= total_reg;
            odrop_reg <= drop_reg;
            olast_reg <= (k_reg == last_k_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = odrop_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = M_TDATA_W'({otot_reg, oval_reg, s_reg, r_reg, q_reg, p_reg});

endmodule

FILE: sv/isu_checker.sv
// Port-level checker for the integral symmetry unfolder, with its bind.
`include "integral_symmetry_unfolder_assert.svh"

module isu_checker #(
    parameter int INDEX_BITS = 8,
    parameter int M_TDATA_W  = 112
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser,
    input logic                 m_tlast
);
    // a stalled result word holds still
    `ISU_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // a dropped integral yields exactly one word
    `ISU_ASSERT_NOW(a_drop_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
    // a dropped word carries zero indices
    `ISU_ASSERT_NOW(a_drop_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[4*INDEX_BITS-1:0] == '0)
    // copies of one integral leave without gaps
    `ISU_ASSERT_NEXT(a_copy_gapless, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

bind integral_symmetry_unfolder isu_checker #(
    .INDEX_BITS (INDEX_BITS),
    .M_TDATA_W  (M_TDATA_W)
) u_isu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
